>>> src/iss_pkg.sv
// shared types and constants of the integer set sorter
package iss_pkg;

   localparam int MAX_ITEMS_DEFAULT  = 64;
   localparam int VALUE_BITS_DEFAULT = 32;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_cmd_type;

endpackage

>>> src/iss_cell.sv
// one sorting cell: holds a value and keeps the row ascending
module iss_cell #(
   parameter int VALUE_BITS = iss_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  iss_pkg::cell_cmd_type        cmd,
   input  logic signed [VALUE_BITS-1:0] new_value,
   input  logic                         left_place,
   input  logic                         left_occ,
   input  logic signed [VALUE_BITS-1:0] left_value,
   input  logic                         right_occ,
   input  logic signed [VALUE_BITS-1:0] right_value,
   output logic                         place_here,
   output logic                         occ,
   output logic signed [VALUE_BITS-1:0] value
);
   import iss_pkg::*;

   logic                         occ_ff;
   logic                         occ_in;
   logic signed [VALUE_BITS-1:0] value_ff;
   logic signed [VALUE_BITS-1:0] value_in;

   // empty cells count as larger than anything
   assign place_here = !occ_ff || (new_value < value_ff);

   always_comb begin
      occ_in   = occ_ff;
      value_in = value_ff;
      if (cmd.shift) begin
         occ_in   = right_occ;
         value_in = right_value;
      end else if (cmd.insert && place_here) begin
         if (left_place) begin
            occ_in   = left_occ;
            value_in = left_value;
         end else begin
            occ_in   = 1'b1;
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      value_ff <= value_in;
   end

   assign occ   = occ_ff;
   assign value = value_ff;

endmodule

>>> src/iss_chain.sv
// row of sorting cells, smallest value at the head
module iss_chain #(
   parameter int MAX_ITEMS  = iss_pkg::MAX_ITEMS_DEFAULT,
   parameter int VALUE_BITS = iss_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  iss_pkg::cell_cmd_type        cmd,
   input  logic signed [VALUE_BITS-1:0] new_value,
   output logic                         head_occ,
   output logic signed [VALUE_BITS-1:0] head_value
);
   import iss_pkg::*;

   logic                         place [MAX_ITEMS];
   logic                         occ   [MAX_ITEMS];
   logic signed [VALUE_BITS-1:0] value [MAX_ITEMS];

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic                         l_place;
      logic                         l_occ;
      logic signed [VALUE_BITS-1:0] l_value;
      logic                         r_occ;
      logic signed [VALUE_BITS-1:0] r_value;

      if (i == 0) begin : g_head
         assign l_place = 1'b0;
         assign l_occ   = 1'b0;
         assign l_value = '0;
      end else begin : g_body
         assign l_place = place[i-1];
         assign l_occ   = occ[i-1];
         assign l_value = value[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign r_occ   = 1'b0;
         assign r_value = '0;
      end else begin : g_inner
         assign r_occ   = occ[i+1];
         assign r_value = value[i+1];
      end

      iss_cell #(
         .VALUE_BITS(VALUE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .new_value  (new_value),
         .left_place (l_place),
         .left_occ   (l_occ),
         .left_value (l_value),
         .right_occ  (r_occ),
         .right_value(r_value),
         .place_here (place[i]),
         .occ        (occ[i]),
         .value      (value[i])
      );
   end

   assign head_occ   = occ[0];
   assign head_value = value[0];

endmodule

>>> src/integer_set_sorter_core.sv
// integer set sorter: loads a set into a cell row, then streams it out ascending
// load: one beat accepted per cycle, each value placed in its sorted slot at once
// after the last beat the smallest value is offered in the next cycle
// results then leave one beat per cycle while rsp_ready is high; no input taken meanwhile
// a set stores at most MAX_ITEMS values; beats that arrive while the row is full are dropped
// reset empties every cell and returns to loading, stored values are not cleared
module integer_set_sorter_core #(
   parameter int MAX_ITEMS  = iss_pkg::MAX_ITEMS_DEFAULT,
   parameter int VALUE_BITS = iss_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic                         req_last_item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [VALUE_BITS-1:0] rsp_sorted_value,
   output logic                         rsp_final_result
);
   import iss_pkg::*;

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   state_type    state_ff;
   state_type    state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   cell_cmd_type cmd;
   logic         head_occ;
   logic         req_beat;
   logic         rsp_beat;
   logic         full;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;
   assign full     = (count_ff == CNT_W'(MAX_ITEMS));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_beat && req_last_item) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_beat && rsp_final_result) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd.insert = 1'b0;
      cmd.shift  = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready  = 1'b1;
            cmd.insert = req_valid && !full;
         end
         ST_DRAIN: begin
            rsp_valid = 1'b1;
            cmd.shift = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rsp_beat) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   iss_chain #(
      .MAX_ITEMS (MAX_ITEMS),
      .VALUE_BITS(VALUE_BITS)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .new_value (req_value),
      .head_occ  (head_occ),
      .head_value(rsp_sorted_value)
   );

   assign rsp_final_result = (count_ff == CNT_W'(1));

   a_head_filled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> head_occ && (count_ff != '0))
      else $error("result offered from an empty row");

   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_last_item) |=> (state_ff == ST_DRAIN))
      else $error("last beat did not start output");

   a_final_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_final_result) |=> (count_ff == '0) && !head_occ)
      else $error("row not empty after final beat");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("count beyond capacity");

endmodule

>>> verif/integer_set_sorter_core_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the integer set sorter: random and directed sets, sorted output checked
module integer_set_sorter_core_test;

   localparam int MAX_ITEMS  = iss_pkg::MAX_ITEMS_DEFAULT;
   localparam int VALUE_BITS = iss_pkg::VALUE_BITS_DEFAULT;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   localparam value_type MOST_NEGATIVE = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam value_type MOST_POSITIVE = {1'b0, {(VALUE_BITS-1){1'b1}}};

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   value_type req_value = '0;
   logic      req_last_item = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   value_type rsp_sorted_value;
   logic      rsp_final_result;

   // set being collected, kept in ascending order as it arrives
   value_type held_values [MAX_ITEMS];
   int        held_count = 0;

   value_type expected_order_q [$];
   bit        expected_final_q [$];

   int        mismatch_count = 0;
   bit        idle_on = 1'b1;
   int        stall_left = 0;

   integer_set_sorter_core #(
      .MAX_ITEMS (MAX_ITEMS),
      .VALUE_BITS(VALUE_BITS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_final_result(rsp_final_result)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("** integer_set_sorter_core: FAILED **");
      $finish;
   end

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch: %s", msg);
      end
   endtask

   // insert into the sorted set; on the last beat the whole set becomes the expected output
   task automatic store_value_sorted(input value_type value, input logic last);
      int slot;
      if (held_count < MAX_ITEMS) begin
         slot = held_count;
         while (slot > 0 && held_values[slot-1] > value) begin
            held_values[slot] = held_values[slot-1];
            slot--;
         end
         held_values[slot] = value;
         held_count++;
      end
      if (last) begin
         for (int i = 0; i < held_count; i++) begin
            expected_order_q.push_back(held_values[i]);
            expected_final_q.push_back(i == held_count - 1);
         end
         held_count = 0;
      end
   endtask

   task automatic send_item(input value_type value, input logic last);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_value     <= value;
      req_last_item <= last;
      do @(posedge clock); while (!req_ready);
      store_value_sorted(value, last);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_order_q.size() != 0) @(posedge clock);
   endtask

   function automatic value_type random_value();
      case ($urandom_range(0, 9))
         6, 7:    return value_type'($urandom_range(0, 8)) - 4;
         8:       return $urandom_range(0, 1) ? MOST_NEGATIVE : MOST_POSITIVE;
         9:       return $urandom_range(0, 1) ? value_type'(-1) : value_type'(0);
         default: return value_type'($urandom);
      endcase
   endfunction

   task automatic send_random_set(input int size);
      for (int i = 0; i < size; i++) begin
         send_item(random_value(), i == size - 1);
      end
   endtask

   function automatic int random_set_size();
      case ($urandom_range(0, 19))
         0:          return $urandom_range(41, MAX_ITEMS + 8);
         1, 2, 3:    return $urandom_range(9, 40);
         default:    return $urandom_range(1, 8);
      endcase
   endfunction

   task automatic test_single_value();
      send_item(-5, 1'b1);
      send_item(MOST_POSITIVE, 1'b1);
   endtask

   task automatic test_extremes_and_duplicates();
      send_item(MOST_POSITIVE, 1'b0);
      send_item(MOST_NEGATIVE, 1'b0);
      send_item(0, 1'b0);
      send_item(-1, 1'b0);
      send_item(1, 1'b0);
      send_item(MOST_NEGATIVE, 1'b0);
      send_item(MOST_POSITIVE, 1'b0);
      send_item(0, 1'b1);
   endtask

   task automatic test_ordered_inputs();
      for (int i = 1; i <= 6; i++) begin
         send_item(i, i == 6);
      end
      for (int i = 6; i >= 1; i--) begin
         send_item(-i, i == 1);
      end
   endtask

   // store exactly full, then overflowing with the last beat itself dropped
   task automatic test_full_store();
      send_random_set(MAX_ITEMS);
      send_random_set(MAX_ITEMS + 3);
   endtask

   task automatic test_pause_until_drained();
      send_random_set(5);
      wait_results_drained();
      send_random_set(12);
      wait_results_drained();
   endtask

   task automatic test_random_sets(input int item_budget);
      int sent;
      int size;
      sent = 0;
      while (sent < item_budget) begin
         size = random_set_size();
         send_random_set(size);
         sent += size;
      end
   endtask

   task automatic test_back_to_back(input int item_budget);
      idle_on = 1'b0;
      test_random_sets(item_budget);
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 16);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_order_q.size() == 0) begin
            note_mismatch($sformatf("result beat with nothing expected, value %0d",
                                    rsp_sorted_value));
         end else begin
            if (rsp_sorted_value !== expected_order_q[0]) begin
               note_mismatch($sformatf("sorted_value expected %0d, got %0d",
                                       expected_order_q[0], rsp_sorted_value));
            end
            if (rsp_final_result !== expected_final_q[0]) begin
               note_mismatch($sformatf("final_result expected %0d, got %0d",
                                       expected_final_q[0], rsp_final_result));
            end
            void'(expected_order_q.pop_front());
            void'(expected_final_q.pop_front());
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_value();
      test_extremes_and_duplicates();
      test_ordered_inputs();
      test_full_store();
      test_pause_until_drained();
      test_random_sets(260);
      test_back_to_back(60);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_order_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);

      if (mismatch_count == 0 && expected_order_q.size() == 0) begin
         $display("** integer_set_sorter_core: PASSED **");
      end else begin
         $display("** integer_set_sorter_core: FAILED **");
      end
      $finish;
   end

endmodule

>>> integer_set_sorter_core.f
src/iss_pkg.sv
src/iss_cell.sv
src/iss_chain.sv
src/integer_set_sorter_core.sv
verif/integer_set_sorter_core_test.sv
